// ===== rtl/spq_pkg.sv =====
// Package for the sorted priority queue: sizes, cell, request and result types.
// No dependencies; every other file in rtl/ uses it through scoped names.
`default_nettype none

package spq_pkg;

	localparam int DEPTH     = 16;
	localparam int PRIO_BITS = 16;
	localparam int DATA_BITS = 32;
	localparam int CNT_BITS  = $clog2(DEPTH + 1);
	localparam int LEN_BITS  = 5;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic [PRIO_BITS-1:0] priority_req;
		logic [DATA_BITS-1:0] payload;
	} req_t;

	typedef struct packed {
		logic                 out_valid;
		logic [PRIO_BITS-1:0] out_priority;
		logic [DATA_BITS-1:0] out_payload;
		logic [PRIO_BITS-1:0] head_priority;
		logic [DATA_BITS-1:0] head_payload;
		logic                 is_empty;
		logic                 dropped;
		logic [LEN_BITS-1:0]  length;
	} res_t;

	// Contents of one cell of the sorted row.
	typedef struct packed {
		logic                 valid;
		logic [PRIO_BITS-1:0] prio;
		logic [DATA_BITS-1:0] data;
	} cell_t;

	// Operation broadcast to every cell in the cycle of a transfer.
	typedef struct packed {
		logic                 ins;
		logic                 rem;
		logic [PRIO_BITS-1:0] prio;
		logic [DATA_BITS-1:0] data;
	} cell_op_t;

endpackage

`default_nettype wire

// ===== rtl/spq_if.sv =====
// Valid/ready channel interfaces for requests and results of the queue.
// Depends on spq_pkg for the payload types.
`default_nettype none

interface spq_req_if;
	logic          valid;
	logic          ready;
	spq_pkg::req_t pl;

	modport source (output valid, output pl, input ready);
	modport sink   (input valid, input pl, output ready);
endinterface

interface spq_res_if;
	logic          valid;
	logic          ready;
	spq_pkg::res_t pl;

	modport source (output valid, output pl, input ready);
	modport sink   (input valid, input pl, output ready);
endinterface

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One slot of the sorted row: compares the broadcast priority with its own
// and keeps, takes the new entry or takes a neighbour. Depends on spq_pkg.
`default_nettype none

module spq_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire spq_pkg::cell_op_t op,
	input  wire spq_pkg::cell_t    left,
	input  wire logic              left_le,
	input  wire spq_pkg::cell_t    right,
	output spq_pkg::cell_t         cur,
	output logic                   le,
	output spq_pkg::cell_t         nxt
);

	logic                          valid_q;
	logic [spq_pkg::PRIO_BITS-1:0] prio_q;
	logic [spq_pkg::DATA_BITS-1:0] data_q;

	assign cur = '{valid: valid_q, prio: prio_q, data: data_q};
	// Equal priorities stay ahead of the new entry.
	assign le  = valid_q && (prio_q <= op.prio);

	always_comb begin
		nxt = cur;
		if (op.ins) begin
			if (le) begin
				nxt = cur;
			end else if (left_le) begin
				nxt = '{valid: 1'b1, prio: op.prio, data: op.data};
			end else begin
				nxt = left;
			end
		end else if (op.rem) begin
			nxt = right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		prio_q <= nxt.prio;
		data_q <= nxt.data;
	end

endmodule

`default_nettype wire

// ===== rtl/spq_out_buf.sv =====
// Two-entry result buffer: output register plus skid register.
// Depends on spq_pkg for the result type.
`default_nettype none

module spq_out_buf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire spq_pkg::res_t push_pl,
	output logic               space,
	output logic               valid,
	input  wire logic          ready,
	output spq_pkg::res_t      pl
);

	logic          v0_q;
	logic          v1_q;
	spq_pkg::res_t r0_q;
	spq_pkg::res_t r1_q;
	logic          pop;

	assign pop   = v0_q && ready;
	assign space = !v1_q;
	assign valid = v0_q;
	assign pl    = r0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else if (pop) begin
			v0_q <= v1_q || push;
			v1_q <= 1'b0;
		end else if (push) begin
			v0_q <= 1'b1;
			v1_q <= v0_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			r0_q <= v1_q ? r1_q : push_pl;
		end else if (push) begin
			if (v0_q) begin
				r1_q <= push_pl;
			end else begin
				r0_q <= push_pl;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue_unit.sv =====
// Top level of the sorted priority queue: a row of spq_cell slots with the
// result buffer spq_out_buf. Depends on spq_pkg and spq_if.
//
//   channel | dir | payload                      | transfer when
//   req     | in  | cmd, priority_req, payload   | req.valid && req.ready
//   res     | out | removed entry, head, length  | res.valid && res.ready
//
// One request per cycle while req.ready is high: every cell compares the broadcast
// priority with its own in parallel and keeps or takes new entry, left or right
// neighbour. A result appears on res in the cycle after its request transfers at
// the earliest; behind an unread result it waits in the second result register.
// req.ready falls only while both result registers are full (res stalled).
// Reset clears every valid bit and the length; no clearing pass is needed.
`default_nettype none

module sorted_priority_queue_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	spq_req_if.sink   req,
	spq_res_if.source res
);

	localparam int N = spq_pkg::DEPTH;

	spq_pkg::cell_t    cur   [N];
	spq_pkg::cell_t    nxt   [N];
	spq_pkg::cell_t    lefts [N];
	spq_pkg::cell_t    rights[N];
	logic              le    [N];
	logic              lles  [N];
	spq_pkg::cell_op_t op;
	spq_pkg::res_t     res_d;

	logic                         space;
	logic                         xfer;
	logic                         full;
	logic                         is_ins;
	logic                         is_rem;
	logic [spq_pkg::CNT_BITS-1:0] count_q;
	logic [spq_pkg::CNT_BITS-1:0] count_d;

	// Accept whenever the result buffer has a free slot.
	assign req.ready = space;
	assign xfer      = req.valid && req.ready;
	assign full      = count_q == spq_pkg::CNT_BITS'(N);
	assign is_ins    = xfer && (req.pl.cmd == spq_pkg::CMD_INSERT);
	assign is_rem    = xfer && (req.pl.cmd == spq_pkg::CMD_REMOVE);

	// Drop inserts into a full row; removes on an empty row shift invalid cells only.
	assign op = '{ins: is_ins && !full, rem: is_rem,
		prio: req.pl.priority_req, data: req.pl.payload};

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			if (g == 0) begin : g_head
				assign lefts[g] = '0;
				assign lles[g]  = 1'b1;
			end else begin : g_mid
				assign lefts[g] = cur[g-1];
				assign lles[g]  = le[g-1];
			end
			if (g == N - 1) begin : g_tail
				assign rights[g] = '0;
			end else begin : g_body
				assign rights[g] = cur[g+1];
			end

			spq_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.op     (op),
				.left   (lefts[g]),
				.left_le(lles[g]),
				.right  (rights[g]),
				.cur    (cur[g]),
				.le     (le[g]),
				.nxt    (nxt[g])
			);
		end
	endgenerate

	// Track the fill level alongside the row.
	always_comb begin
		count_d = count_q;
		if (op.ins) begin
			count_d = count_q + 1'b1;
		end else if (is_rem && count_q != '0) begin
			count_d = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// Build the result from the head as it leaves and as it will be.
	always_comb begin
		res_d               = '0;
		res_d.out_valid     = is_rem && cur[0].valid;
		if (is_rem && cur[0].valid) begin
			res_d.out_priority = cur[0].prio;
			res_d.out_payload  = cur[0].data;
		end
		if (nxt[0].valid) begin
			res_d.head_priority = nxt[0].prio;
			res_d.head_payload  = nxt[0].data;
		end
		res_d.is_empty = !nxt[0].valid;
		res_d.dropped  = is_ins && full;
		res_d.length   = spq_pkg::LEN_BITS'(count_d);
	end

	spq_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (xfer),
		.push_pl(res_d),
		.space  (space),
		.valid  (res.valid),
		.ready  (res.ready),
		.pl     (res.pl)
	);

endmodule

`default_nettype wire

// ===== rtl/spq_checker.sv =====
// Port-level checks on sorted_priority_queue_unit results, bound to the top.
// Depends on spq_pkg and the top level's channel ports.
`default_nettype none

module spq_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          res_valid,
	input wire logic          res_ready,
	input wire spq_pkg::res_t res_pl
);

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_pl.dropped |->
			res_pl.length == spq_pkg::LEN_BITS'(spq_pkg::DEPTH))
		else $error("drop reported below full length");

	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_pl.is_empty == (res_pl.length == '0))
		else $error("empty flag disagrees with length");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_pl.is_empty |->
			res_pl.head_priority == '0 && res_pl.head_payload == '0)
		else $error("head not zero on empty queue");

	a_remove_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_pl.out_valid |-> !res_pl.dropped)
		else $error("removal and drop in one result");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_pl))
		else $error("stalled result changed");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_pl   (res.pl)
);

`default_nettype wire

// ===== tb/sorted_priority_queue_unit_tb.sv =====
// Self-checking bench for sorted_priority_queue_unit: directed and random insert/remove
// traffic, each result checked against an in-bench sorted-list prediction.
// Depends on spq_pkg and spq_if from rtl/.
`default_nettype none

module sorted_priority_queue_unit_tb;

	import spq_pkg::*;

	localparam int TOTAL_ITEMS = 1250;
	localparam int HOLD_CYCLES = 80;

	logic clk;
	logic arst_n;

	spq_req_if req_ch ();
	spq_res_if res_ch ();

	sorted_priority_queue_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	always #10 clk = ~clk;

	// Shadow of the queue contents, head at index 0.
	logic [PRIO_BITS-1:0] shadow_prio [DEPTH];
	logic [DATA_BITS-1:0] shadow_data [DEPTH];
	int                   shadow_len;

	req_t req_backlog [$];       // requests not yet offered to the block
	res_t expected_results [$];  // predicted results, oldest first

	int total_reqs;
	int n_sent;
	int n_checked;
	int mismatch_count;
	int n_inserted, n_removed, n_dropped, n_empty_removes, peak_len;
	int long_holds;

	// Work out the result of one request and advance the shadow queue.
	function automatic res_t apply_request(req_t r);
		res_t res;
		int   pos;
		res = '0;
		if (r.cmd == CMD_INSERT) begin
			if (shadow_len >= DEPTH) begin
				res.dropped = 1'b1;
				n_dropped++;
			end else begin
				pos = 0;
				while (pos < shadow_len && shadow_prio[pos] <= r.priority_req)
					pos++;
				for (int i = shadow_len; i > pos; i--) begin
					shadow_prio[i] = shadow_prio[i-1];
					shadow_data[i] = shadow_data[i-1];
				end
				shadow_prio[pos] = r.priority_req;
				shadow_data[pos] = r.payload;
				shadow_len++;
				n_inserted++;
				if (shadow_len > peak_len)
					peak_len = shadow_len;
			end
		end else if (shadow_len == 0) begin
			n_empty_removes++;
		end else begin
			res.out_valid    = 1'b1;
			res.out_priority = shadow_prio[0];
			res.out_payload  = shadow_data[0];
			for (int i = 1; i < shadow_len; i++) begin
				shadow_prio[i-1] = shadow_prio[i];
				shadow_data[i-1] = shadow_data[i];
			end
			shadow_len--;
			n_removed++;
		end
		if (shadow_len > 0) begin
			res.head_priority = shadow_prio[0];
			res.head_payload  = shadow_data[0];
		end
		res.is_empty = (shadow_len == 0);
		res.length   = LEN_BITS'(shadow_len);
		return res;
	endfunction

	task automatic compare_field(string name, longint unsigned got, longint unsigned want);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endtask

	task automatic queue_req(cmd_t cmd, logic [PRIO_BITS-1:0] prio, logic [DATA_BITS-1:0] data);
		req_t r;
		r.cmd          = cmd;
		r.priority_req = prio;
		r.payload      = data;
		req_backlog.push_back(r);
	endtask

	// Priorities mostly from a narrow band so that ties are common.
	function automatic logic [PRIO_BITS-1:0] pick_priority();
		int sel;
		sel = $urandom_range(0, 7);
		if (sel < 4)
			return PRIO_BITS'($urandom_range(0, 7));
		else if (sel == 4)
			return '0;
		else if (sel == 5)
			return '1;
		else
			return PRIO_BITS'($urandom);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus: directed opening, then random phases that fill and drain.
	// ------------------------------------------------------------------
	initial begin
		logic [PRIO_BITS-1:0] fill_prio [16];
		int phase_left;
		int insert_pct;
		cmd_t cmd;

		clk          = 1'b0;
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.pl    = '0;
		res_ch.ready = 1'b0;

		fill_prio = '{16'h8000, 16'hFFFF, 16'h0000, 16'h8000, 16'h8000, 16'h0000,
			16'hFFFF, 16'h0001, 16'h7FFF, 16'h8001, 16'h0000, 16'hFFFE,
			16'h8000, 16'h5555, 16'hAAAA, 16'hFFFF};

		// Remove down to empty, then remove from the empty queue.
		queue_req(CMD_INSERT, 16'h1234, 32'hDEAD_BEEF);
		queue_req(CMD_REMOVE, 16'hFFFF, 32'hFFFF_FFFF);
		queue_req(CMD_REMOVE, 16'h0000, 32'h0000_0000);
		// Fill to the brim with extremes and ties, so arrival order matters.
		for (int i = 0; i < 16; i++)
			queue_req(CMD_INSERT, fill_prio[i], (i % 2) ? 32'hFFFF_FFFF - i : 32'h5A5A_0000 + i);
		// Insert into a full queue: dropped.
		queue_req(CMD_INSERT, 16'h0000, 32'h0123_4567);
		queue_req(CMD_REMOVE, 16'h0000, 32'h0000_0000);
		queue_req(CMD_REMOVE, 16'hFFFF, 32'hFFFF_FFFF);

		// Random phases: fill-biased, drain-biased and balanced.
		phase_left = 0;
		insert_pct = 50;
		while (req_backlog.size() < TOTAL_ITEMS) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(5, 40);
				case ($urandom_range(0, 2))
					0: insert_pct = 85;
					1: insert_pct = 15;
					default: insert_pct = 50;
				endcase
			end
			phase_left--;
			cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
			queue_req(cmd, pick_priority(), $urandom);
		end
		total_reqs = req_backlog.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// Driver: offer requests in bursts; predict at each transfer.
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (req_ch.valid && !req_ch.ready) begin
			// hold the offered request until it transfers
		end else begin
			if (req_ch.valid) begin
				expected_results.push_back(apply_request(req_ch.pl));
				n_sent++;
			end
			if (gap_left > 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (req_backlog.size() > 0) begin
				req_ch.valid <= 1'b1;
				req_ch.pl    <= req_backlog.pop_front();
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					// new burst; about a third of them run back to back with no gap
					burst_left = $urandom_range(1, 30);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: stall on a rotating pattern, with long hold-offs that let
	// the block fill up and push back on its request side.
	// ------------------------------------------------------------------
	int rx_cycle  = 0;
	int hold_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			rx_cycle++;
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if ((long_holds == 0 && n_sent >= 300) ||
					(long_holds == 1 && n_sent >= 900)) begin
				long_holds++;
				hold_left = HOLD_CYCLES;
				res_ch.ready <= 1'b0;
			end else begin
				case ((rx_cycle / 64) % 4)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= (rx_cycle % 3 == 0);
					2: res_ch.ready <= 1'($urandom_range(0, 1));
					default: res_ch.ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check every result transfer against the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = res_ch.pl;
			if (expected_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: result with none expected, actual 0x%0h", $time, got);
			end else begin
				want = expected_results.pop_front();
				compare_field("out_valid",     got.out_valid,     want.out_valid);
				compare_field("out_priority",  got.out_priority,  want.out_priority);
				compare_field("out_payload",   got.out_payload,   want.out_payload);
				compare_field("head_priority", got.head_priority, want.head_priority);
				compare_field("head_payload",  got.head_payload,  want.head_payload);
				compare_field("is_empty",      got.is_empty,      want.is_empty);
				compare_field("dropped",       got.dropped,       want.dropped);
				compare_field("length",        got.length,        want.length);
				n_checked++;
			end
		end
	end

	// ------------------------------------------------------------------
	// End of run: drain, let stray results show up, then report.
	// ------------------------------------------------------------------
	initial begin
		wait (arst_n === 1'b1);
		while (n_sent < total_reqs || expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Checked %0d results from %0d requests: %0d inserted, %0d removed, %0d dropped,",
			n_checked, n_sent, n_inserted, n_removed, n_dropped);
		$display("%0d removes on empty, peak length %0d, %0d long result hold-offs.",
			n_empty_removes, peak_len, long_holds);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#4000000;
		$display("Run timed out with %0d results outstanding", expected_results.size());
		$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/spq_out_buf.sv
rtl/sorted_priority_queue_unit.sv
rtl/spq_checker.sv
tb/sorted_priority_queue_unit_tb.sv
